@@ design/cfmh_pkg.sv @@
// Shared constants, types and helpers for the case-folded MurmurHash2 block.
package cfmh_pkg;

    localparam int unsigned C_HASH_W = 32;
    localparam int unsigned C_LEN_W = 16;
    localparam int unsigned C_IDX_W = 1;

    localparam logic [C_HASH_W-1:0] C_MIX_MUL = 32'h5bd1_e995;
    localparam logic [C_HASH_W-1:0] C_SEED_RESET = 32'h3141_5926;

    localparam int unsigned C_SHIFT_K = 24;
    localparam int unsigned C_SHIFT_A = 13;
    localparam int unsigned C_SHIFT_B = 15;

    localparam logic [C_IDX_W-1:0] C_REG_SEED = 1'b0;
    localparam logic [C_IDX_W-1:0] C_REG_FOLD = 1'b1;

    typedef struct packed {
        logic [C_HASH_W-1:0] hash_seed;
        logic                fold_case;
    } t_cfg;

    // ASCII A-Z to a-z when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
        logic [7:0] r;
        r = b;
        if (fold && b >= 8'h41 && b <= 8'h5a) begin
            r = b | 8'h20;
        end
        return r;
    endfunction

endpackage

@@ design/cfmh_if.sv @@
// Handshake channel interfaces: byte input, hash output, register writes.
interface cfmh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        first;
    logic [15:0] total_length;
    logic        last;

    modport source(output valid, data_byte, byte_valid, first, total_length, last,
                   input ready);
    modport sink(input valid, data_byte, byte_valid, first, total_length, last,
                 output ready);
endinterface

interface cfmh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source(output valid, hash_value, input ready);
    modport sink(input valid, hash_value, output ready);
endinterface

interface cfmh_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ design/cfmh_mul.sv @@
// Shared multiplier by the mixing constant, registered output.
module cfmh_mul (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [cfmh_pkg::C_HASH_W-1:0] i_a,
    output logic [cfmh_pkg::C_HASH_W-1:0] o_p
);
    import cfmh_pkg::*;

    logic [C_HASH_W-1:0] r_prod;
    logic [C_HASH_W-1:0] n_prod;

    // low 32 bits of the product only
    assign n_prod = i_a * C_MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_p = r_prod;
endmodule

@@ design/cfmh_cfg.sv @@
// Configuration registers: seed and case-fold enable.
module cfmh_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cfmh_cfg_if.sink       i_cfg,
    output cfmh_pkg::t_cfg o_cfg
);
    import cfmh_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hash_seed <= C_SEED_RESET;
            r_cfg.fold_case <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                C_REG_SEED: r_cfg.hash_seed <= i_cfg.data;
                C_REG_FOLD: r_cfg.fold_case <= i_cfg.data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ design/cfmh_seq.sv @@
// Sequencer and datapath registers; drives the shared multiplier.
module cfmh_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfmh_pkg::t_cfg                i_cfg,
    cfmh_in_if.sink                       i_in,
    cfmh_out_if.source                    o_out,
    output logic                          o_mul_en,
    output logic [cfmh_pkg::C_HASH_W-1:0] o_mul_a,
    input  logic [cfmh_pkg::C_HASH_W-1:0] i_mul_p
);
    import cfmh_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_K1   = 9'b000000010,
        S_K2   = 9'b000000100,
        S_K3   = 9'b000001000,
        S_K4   = 9'b000010000,
        S_TL   = 9'b000100000,
        S_TL2  = 9'b001000000,
        S_AV1  = 9'b010000000,
        S_AV2  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [C_HASH_W-1:0] r_acc, n_acc;
    logic [23:0]         r_pend, n_pend;
    logic [1:0]          r_cnt, n_cnt;
    logic [C_HASH_W-1:0] r_work, n_work;
    logic                r_last, n_last;
    logic [C_HASH_W-1:0] r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                accept;
    logic [7:0]          fb;
    logic [C_HASH_W-1:0] acc0;
    logic [23:0]         pend0, pend1;
    logic [1:0]          cnt0, cnt1;
    logic [C_HASH_W-1:0] mix;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.hash_value = r_out;

    always_comb begin
        fb = fold_byte(i_in.data_byte, i_cfg.fold_case);
        acc0 = i_in.first ? (i_cfg.hash_seed ^ C_HASH_W'(i_in.total_length)) : r_acc;
        pend0 = i_in.first ? 24'd0 : r_pend;
        cnt0 = i_in.first ? 2'd0 : r_cnt;
        pend1 = pend0;
        cnt1 = cnt0;
        if (i_in.byte_valid) begin
            pend1 = pend0 | (24'(fb) << {cnt0, 3'b000});
            cnt1 = cnt0 + 2'd1;
        end
        mix = i_mul_p ^ r_work;

        n_state = r_state;
        n_acc = r_acc;
        n_pend = r_pend;
        n_cnt = r_cnt;
        n_work = r_work;
        n_last = r_last;
        n_out = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        o_mul_en = 1'b0;
        o_mul_a = r_work;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_acc = acc0;
                    n_last = i_in.last;
                    if (i_in.byte_valid && cnt0 == 2'd3) begin
                        // word complete: k = bytes little-endian
                        n_work = {fb, pend0};
                        n_pend = '0;
                        n_cnt = '0;
                        n_state = S_K1;
                    end else if (i_in.last) begin
                        n_work = acc0 ^ C_HASH_W'(pend1);
                        n_acc = '0;
                        n_pend = '0;
                        n_cnt = '0;
                        n_state = (cnt1 != 2'd0) ? S_TL : S_AV1;
                    end else begin
                        n_pend = pend1;
                        n_cnt = cnt1;
                    end
                end
            end
            S_K1: begin
                o_mul_en = 1'b1;
                o_mul_a = r_work;
                n_state = S_K2;
            end
            S_K2: begin
                o_mul_en = 1'b1;
                o_mul_a = i_mul_p ^ (i_mul_p >> C_SHIFT_K);
                n_state = S_K3;
            end
            S_K3: begin
                o_mul_en = 1'b1;
                o_mul_a = r_acc;
                n_work = i_mul_p;
                n_state = S_K4;
            end
            S_K4: begin
                if (r_last) begin
                    n_acc = '0;
                    n_work = mix;
                    n_state = S_AV1;
                end else begin
                    n_acc = mix;
                    n_state = S_IDLE;
                end
            end
            S_TL: begin
                o_mul_en = 1'b1;
                o_mul_a = r_work;
                n_state = S_TL2;
            end
            S_TL2: begin
                n_work = i_mul_p;
                n_state = S_AV1;
            end
            S_AV1: begin
                o_mul_en = 1'b1;
                o_mul_a = r_work ^ (r_work >> C_SHIFT_A);
                n_state = S_AV2;
            end
            S_AV2: begin
                // hold here while the output register is still full
                if (!r_out_valid || o_out.ready) begin
                    n_out = i_mul_p ^ (i_mul_p >> C_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc <= '0;
            r_pend <= '0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc <= n_acc;
            r_pend <= n_pend;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_last <= n_last;
        r_out <= n_out;
    end
endmodule

@@ design/case_folded_murmur2_string_hash_top.sv @@
// Top level of the streaming case-folded MurmurHash2 (32-bit) string hasher.
//
// Usage: strings enter on i_in, one byte per word; first marks the start and
// carries total_length, last marks the end, byte_valid low means no byte (the
// single word of an empty string). One hash word leaves on o_out per string.
// Registers are written on i_cfg: index 0 is the seed, index 1 the case-fold
// enable; cfg is always ready; the user writes it only while idle (unchecked).
//
// Timing: a byte that does not complete a 4-byte word leaves the FSM idle
// and the next word is taken on the following cycle. A byte that completes a
// word runs S_K1 to S_K4: the word mix runs three products through the one
// shared multiplier, each registered. A last word goes on to S_AV1 and S_AV2
// (after S_TL and S_TL2 if tail bytes remain); S_AV2 loads the hash into the
// o_out register, waiting there while that register is still full.
//
// Reset (synchronous, active low) clears the accumulator, pending bytes and
// output valid, and reloads the seed and fold registers. A stalled receiver
// holds the finished hash in the output register; the next string can still
// be streamed, and only its final hash waits for the register to free up.
module case_folded_murmur2_string_hash_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfmh_in_if.sink    i_in,
    cfmh_out_if.source o_out,
    cfmh_cfg_if.sink   i_cfg
);
    import cfmh_pkg::*;

    t_cfg                cfg;
    logic                mul_en;
    logic [C_HASH_W-1:0] mul_a;
    logic [C_HASH_W-1:0] mul_p;

    cfmh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cfmh_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .o_p   (mul_p)
    );

    cfmh_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_mul_en (mul_en),
        .o_mul_a  (mul_a),
        .i_mul_p  (mul_p)
    );
endmodule
